// ===== hdl/two_party_deadlock_detector_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-party deadlock detector
// Clocked concurrent checks with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef TWO_PARTY_DEADLOCK_DETECTOR_ASSERT_SVH
`define TWO_PARTY_DEADLOCK_DETECTOR_ASSERT_SVH

// Same-cycle implication
`define TPDD_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tpdd assertion failed");

// Next-cycle implication
`define TPDD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tpdd assertion failed");

`endif

// ===== hdl/tpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpdd_pkg
// Shared widths, command codes and control types of the deadlock detector.
// ----------------------------------------------------------------------------
package tpdd_pkg;

  // Default table size
  localparam int DEF_NUM_REQUESTERS = 8;
  localparam int DEF_NUM_RESOURCES  = 16;

  // Fixed field widths
  localparam int CMD_W = 3;
  localparam int REQ_W = 3;
  localparam int RES_W = 4;

  // Event commands
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WAIT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNWAIT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             upd;    // apply a per-requester event
    logic             clr;    // empty both tables
    logic             load;   // take the neighbor's maps as probe
    logic             shift;  // pass the probe one cell on
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] requester;
  } cell_ctrl_t;

endpackage

// ===== hdl/tpdd_cell.sv =====
// ----------------------------------------------------------------------------
// tpdd_cell
// One requester's held and waiting bitmaps plus a circulating probe slot
// that is compared against the local maps for a mutual wait.
// ----------------------------------------------------------------------------
module tpdd_cell import tpdd_pkg::*; #(
  parameter int NUM_RESOURCES = DEF_NUM_RESOURCES,
  parameter int IDX           = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic [NUM_RESOURCES-1:0] res_mask,
  input  logic [NUM_RESOURCES-1:0] nb_held,
  input  logic [NUM_RESOURCES-1:0] nb_wait,
  input  logic [NUM_RESOURCES-1:0] nb_probe_held,
  input  logic [NUM_RESOURCES-1:0] nb_probe_wait,
  output logic [NUM_RESOURCES-1:0] held,
  output logic [NUM_RESOURCES-1:0] waiting,
  output logic [NUM_RESOURCES-1:0] probe_held,
  output logic [NUM_RESOURCES-1:0] probe_wait,
  output logic                     match
);

  logic                     sel;
  logic [NUM_RESOURCES-1:0] held_next;
  logic [NUM_RESOURCES-1:0] waiting_next;

  assign sel = ctrl.upd && (32'(ctrl.requester) == IDX);

  // Table update for this requester
  always_comb begin
    held_next    = held;
    waiting_next = waiting;
    if (ctrl.clr) begin
      held_next    = '0;
      waiting_next = '0;
    end else if (sel) begin
      unique case (ctrl.cmd)
        CMD_ACQUIRE: begin
          held_next    = held | res_mask;
          waiting_next = waiting & ~res_mask;
        end
        CMD_RELEASE: held_next    = held & ~res_mask;
        CMD_WAIT:    waiting_next = waiting | res_mask;
        CMD_UNWAIT:  waiting_next = waiting & ~res_mask;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= '0;
      waiting <= '0;
    end else begin
      held    <= held_next;
      waiting <= waiting_next;
    end
  end

  // Probe slot: loaded from the neighbor's maps, then passed along the ring
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      probe_held <= nb_held;
      probe_wait <= nb_wait;
    end else if (ctrl.shift) begin
      probe_held <= nb_probe_held;
      probe_wait <= nb_probe_wait;
    end
  end

  // Each side waits on something the other holds
  assign match = (|(waiting & probe_held)) && (|(probe_wait & held));

endmodule

// ===== hdl/two_party_deadlock_detector.sv =====
// ----------------------------------------------------------------------------
// two_party_deadlock_detector
// Lock-table monitor: per-requester held/waiting bitmaps in a ring of cells,
// reporting after every event whether two requesters wait on each other.
// ----------------------------------------------------------------------------
//  channel  | ports                          | transfer when
//  ---------+--------------------------------+---------------------------
//  event in | start, busy, cmd, requester,   | start && !busy
//           | resource                       |
//  result   | strobe, deadlock               | strobe (one cycle)
//
//  An event is applied at its transfer edge; the check then runs a load
//  step and a run of scan steps, one probe rotation per cycle. The result
//  strobes in the done state after the last scan step, and busy stays high
//  until that strobe cycle ends, so a new event is taken only after it.
//  Reset empties both tables. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module two_party_deadlock_detector import tpdd_pkg::*; #(
  parameter int NUM_REQUESTERS = DEF_NUM_REQUESTERS,
  parameter int NUM_RESOURCES  = DEF_NUM_RESOURCES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] cmd,
  input  logic [REQ_W-1:0] requester,
  input  logic [RES_W-1:0] resource,
  output logic             strobe,
  output logic             deadlock
);

  `include "two_party_deadlock_detector_assert.svh"

  localparam int CNT_W = (NUM_REQUESTERS > 2) ? $clog2(NUM_REQUESTERS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_REQUESTERS - 2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          cnt, cnt_next;
  logic                      hit, hit_next;
  logic                      accept;
  cell_ctrl_t                ctrl;
  logic [NUM_RESOURCES-1:0]  res_mask;
  logic [NUM_REQUESTERS-1:0] match_vec;

  logic [NUM_RESOURCES-1:0] held    [NUM_REQUESTERS];
  logic [NUM_RESOURCES-1:0] waiting [NUM_REQUESTERS];
  logic [NUM_RESOURCES-1:0] p_held  [NUM_REQUESTERS];
  logic [NUM_RESOURCES-1:0] p_wait  [NUM_REQUESTERS];

  assign accept = start && !busy;

  // Resource decode; an out-of-range index selects no bit
  always_comb begin
    for (int b = 0; b < NUM_RESOURCES; b++) begin
      res_mask[b] = (32'(resource) == b);
    end
  end

  // Control broadcast
  always_comb begin
    ctrl.upd       = accept && (cmd != CMD_CLEAR);
    ctrl.clr       = accept && (cmd == CMD_CLEAR);
    ctrl.load      = (state == ST_LOAD);
    ctrl.shift     = (state == ST_SCAN);
    ctrl.cmd       = cmd;
    ctrl.requester = requester;
  end

  // Ring of requester cells
  for (genvar k = 0; k < NUM_REQUESTERS; k++) begin : g_cell
    localparam int PREV = (k + NUM_REQUESTERS - 1) % NUM_REQUESTERS;
    tpdd_cell #(
      .NUM_RESOURCES (NUM_RESOURCES),
      .IDX           (k)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .res_mask      (res_mask),
      .nb_held       (held[PREV]),
      .nb_wait       (waiting[PREV]),
      .nb_probe_held (p_held[PREV]),
      .nb_probe_wait (p_wait[PREV]),
      .held          (held[k]),
      .waiting       (waiting[k]),
      .probe_held    (p_held[k]),
      .probe_wait    (p_wait[k]),
      .match         (match_vec[k])
    );
  end

  // Sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    hit_next   = hit;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cnt_next   = '0;
        hit_next   = 1'b0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        hit_next = hit | (|match_vec);
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_LAST) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      hit   <= hit_next;
    end
  end

  assign busy     = (state != ST_IDLE);
  assign strobe   = (state == ST_DONE);
  assign deadlock = hit;

  // Checks
  `TPDD_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `TPDD_ASSERT_NEXT(a_strobe_single, clk, rst, strobe, !strobe && !busy)
  `TPDD_ASSERT_NOW(a_result_latency, clk, rst, accept, ##(NUM_REQUESTERS + 1) strobe)
  `TPDD_ASSERT_NOW(a_clear_no_deadlock, clk, rst, accept && (cmd == CMD_CLEAR),
    ##(NUM_REQUESTERS + 1) (strobe && !deadlock))

endmodule

// ===== tb/tpdd_checker.sv =====
// ----------------------------------------------------------------------------
// tpdd_checker
// Watches the event and result channels of the deadlock detector, keeps its
// own copy of the held and waiting tables, predicts the deadlock flag for
// every accepted event and compares it with each strobed result.
// ----------------------------------------------------------------------------
module tpdd_checker import tpdd_pkg::*; #(
  parameter int NUM_REQUESTERS = DEF_NUM_REQUESTERS,
  parameter int NUM_RESOURCES  = DEF_NUM_RESOURCES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [CMD_W-1:0] cmd,
  input  logic [REQ_W-1:0] requester,
  input  logic [RES_W-1:0] resource,
  input  logic             strobe,
  input  logic             deadlock,
  output int               errors,
  output int               pending
);

  // Shadow lock tables
  logic [NUM_RESOURCES-1:0] held_tbl [NUM_REQUESTERS];
  logic [NUM_RESOURCES-1:0] wait_tbl [NUM_REQUESTERS];

  // Expected deadlock flags, oldest first
  logic deadlock_expected_q [$];
  int   mismatch_cnt;
  logic want_flag;

  // Empty both tables
  function automatic void clear_tables();
    for (int i = 0; i < NUM_REQUESTERS; i++) begin
      held_tbl[i] = '0;
      wait_tbl[i] = '0;
    end
  endfunction

  // Update the tables for one event
  function automatic void apply_event(logic [CMD_W-1:0] op, logic [REQ_W-1:0] who,
                                      logic [RES_W-1:0] what);
    logic [NUM_RESOURCES-1:0] bit_mask;
    bit_mask = '0;
    if (op == CMD_CLEAR) begin
      clear_tables();
    end else if (who < NUM_REQUESTERS && what < NUM_RESOURCES) begin
      bit_mask[what] = 1'b1;
      case (op)
        CMD_ACQUIRE: begin
          held_tbl[who] = held_tbl[who] | bit_mask;
          wait_tbl[who] = wait_tbl[who] & ~bit_mask;
        end
        CMD_RELEASE: held_tbl[who] = held_tbl[who] & ~bit_mask;
        CMD_WAIT:    wait_tbl[who] = wait_tbl[who] | bit_mask;
        CMD_UNWAIT:  wait_tbl[who] = wait_tbl[who] & ~bit_mask;
        default: ;  // unused codes leave the tables alone
      endcase
    end
  endfunction

  // Any pair of distinct requesters waiting on each other's held resources
  function automatic logic pair_deadlocked();
    for (int i = 0; i < NUM_REQUESTERS; i++) begin
      for (int j = i + 1; j < NUM_REQUESTERS; j++) begin
        if ((wait_tbl[i] & held_tbl[j]) != '0 && (wait_tbl[j] & held_tbl[i]) != '0)
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Result check first, then the new event's prediction
  always @(posedge clk) begin
    if (rst) begin
      clear_tables();
      deadlock_expected_q.delete();
      mismatch_cnt = 0;
      errors  <= 0;
      pending <= 0;
    end else begin
      if (strobe) begin
        if (deadlock_expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got deadlock=%0b",
                   $time, deadlock);
          mismatch_cnt++;
        end else begin
          want_flag = deadlock_expected_q.pop_front();
          if (deadlock !== want_flag) begin
            $display("%0t: deadlock mismatch: expected %0b, got %0b",
                     $time, want_flag, deadlock);
            mismatch_cnt++;
          end
        end
      end
      if (start && !busy) begin
        apply_event(cmd, requester, resource);
        deadlock_expected_q = {deadlock_expected_q, pair_deadlocked()};
      end
      errors  <= mismatch_cnt;
      pending <= deadlock_expected_q.size();
    end
  end

endmodule

// ===== tb/tb_two_party_deadlock_detector.sv =====
// ----------------------------------------------------------------------------
// tb_two_party_deadlock_detector
// Drives lock events into the deadlock detector: a directed set of mutual
// waits, repeats, self-waits, unused codes and clears, then random events
// mixed with built-up two-party deadlocks under three sender idle profiles.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_two_party_deadlock_detector;
  import tpdd_pkg::*;

  localparam int NUM_REQ       = DEF_NUM_REQUESTERS;
  localparam int NUM_RES       = DEF_NUM_RESOURCES;
  localparam int CMD_MAX       = (1 << CMD_W) - 1;
  localparam int ITEMS_PER_RUN = 465;
  localparam int QUIET_LIMIT   = 2000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [CMD_W-1:0] cmd;
  logic [REQ_W-1:0] requester;
  logic [RES_W-1:0] resource;
  logic             strobe;
  logic             deadlock;
  int               errors;
  int               pending;
  int               quiet_cycles;
  int               sender_idle_pct;
  int               events_sent;

  two_party_deadlock_detector #(
    .NUM_REQUESTERS(NUM_REQ),
    .NUM_RESOURCES (NUM_RES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .requester(requester),
    .resource (resource),
    .strobe   (strobe),
    .deadlock (deadlock)
  );

  tpdd_checker #(
    .NUM_REQUESTERS(NUM_REQ),
    .NUM_RESOURCES (NUM_RES)
  ) chk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .requester(requester),
    .resource (resource),
    .strobe   (strobe),
    .deadlock (deadlock),
    .errors   (errors),
    .pending  (pending)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One event transfer, after an optional idle gap with junk on the fields
  task automatic send_event(logic [CMD_W-1:0] op, logic [REQ_W-1:0] who,
                            logic [RES_W-1:0] what);
    int gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct)
      gap = $urandom_range(1, NUM_REQ + 4);
    repeat (gap) begin
      @(negedge clk);
      start     = 1'b0;
      cmd       = CMD_W'($urandom_range(CMD_MAX));
      requester = REQ_W'($urandom);
      resource  = RES_W'($urandom);
    end
    @(negedge clk);
    start     = 1'b1;
    cmd       = op;
    requester = who;
    resource  = what;
    do @(posedge clk); while (busy);
    events_sent++;
  endtask

  // Two requesters each holding one resource and waiting for the other's
  task automatic build_deadlock();
    logic [REQ_W-1:0] a_req, b_req;
    logic [RES_W-1:0] a_res, b_res;
    a_req = REQ_W'($urandom);
    b_req = a_req + REQ_W'($urandom_range(1, NUM_REQ - 1));
    a_res = RES_W'($urandom);
    b_res = RES_W'($urandom);
    send_event(CMD_ACQUIRE, a_req, a_res);
    send_event(CMD_ACQUIRE, b_req, b_res);
    send_event(CMD_WAIT, a_req, b_res);
    send_event(CMD_WAIT, b_req, a_res);
  endtask

  // Single random event, resources mostly from a small set so they collide
  task automatic random_event();
    int               pick;
    logic [CMD_W-1:0] op;
    logic [RES_W-1:0] what;
    pick = $urandom_range(99);
    if (pick < 30)      op = CMD_ACQUIRE;
    else if (pick < 50) op = CMD_RELEASE;
    else if (pick < 75) op = CMD_WAIT;
    else if (pick < 88) op = CMD_UNWAIT;
    else if (pick < 94) op = CMD_CLEAR;
    else                op = CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, CMD_MAX));
    if ($urandom_range(99) < 70) what = RES_W'($urandom_range(3));
    else                         what = RES_W'($urandom);
    send_event(op, REQ_W'($urandom), what);
  endtask

  // Stimulus and verdict
  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    cmd             = CMD_ACQUIRE;
    requester       = '0;
    resource        = '0;
    sender_idle_pct = 35;
    events_sent     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Mutual wait between the extreme requesters on the extreme resources
    send_event(CMD_ACQUIRE, 3'd0, 4'd0);
    send_event(CMD_ACQUIRE, 3'd7, 4'd15);
    send_event(CMD_WAIT,    3'd0, 4'd15);
    send_event(CMD_WAIT,    3'd7, 4'd0);
    // Unwait breaks it, waiting twice then one unwait clears the bit
    send_event(CMD_UNWAIT,  3'd7, 4'd0);
    send_event(CMD_WAIT,    3'd7, 4'd0);
    send_event(CMD_WAIT,    3'd7, 4'd0);
    send_event(CMD_UNWAIT,  3'd7, 4'd0);
    send_event(CMD_WAIT,    3'd7, 4'd0);
    // Release breaks it, double acquire then one release clears the bit
    send_event(CMD_RELEASE, 3'd0, 4'd0);
    send_event(CMD_ACQUIRE, 3'd0, 4'd0);
    send_event(CMD_ACQUIRE, 3'd0, 4'd0);
    send_event(CMD_RELEASE, 3'd0, 4'd0);
    // Acquiring an awaited resource drops the wait
    send_event(CMD_ACQUIRE, 3'd7, 4'd0);
    // Unused command codes
    send_event(CMD_W'(int'(CMD_CLEAR) + 1), 3'd1, 4'd1);
    send_event(CMD_W'(CMD_MAX), 3'd7, 4'd15);
    // A requester waiting on its own held resource
    send_event(CMD_ACQUIRE, 3'd3, 4'd5);
    send_event(CMD_WAIT,    3'd3, 4'd5);
    // Rebuild a deadlock, then clear with the unused fields at both extremes
    send_event(CMD_WAIT,    3'd0, 4'd5);
    send_event(CMD_WAIT,    3'd3, 4'd0);
    send_event(CMD_ACQUIRE, 3'd0, 4'd0);
    send_event(CMD_CLEAR,   3'd7, 4'd15);
    send_event(CMD_CLEAR,   3'd0, 4'd0);

    // Random part under three idle profiles
    for (int run = 0; run < 3; run++) begin
      sender_idle_pct = (run == 0) ? 35 : (run == 1) ? 56 : 0;
      events_sent = 0;
      while (events_sent < ITEMS_PER_RUN) begin
        if ($urandom_range(99) < 25) build_deadlock();
        else                         random_event();
      end
    end

    @(negedge clk);
    start = 1'b0;

    // Drain, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (NUM_REQ + 4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
